### hdl/flif_pkg.sv
// ----------------------------------------------------------------------------
// flif_pkg
// Shared types, constants and a saturation helper of the fractional
// integrate-and-fire neuron step unit.
// ----------------------------------------------------------------------------
package flif_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REFR_W     = 17;
  localparam int HLEN_W     = 11;
  localparam int TERM_W     = 52;

  localparam logic [CFG_ADDR_W-1:0] CFG_LEAK_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REST_V      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESET_V     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFR_TICKS  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEMORY_GAIN = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIST_LEN    = 3'd7;

  localparam logic [30:0]        RST_LEAK_GAIN   = 31'd6554;
  localparam logic [30:0]        RST_INPUT_GAIN  = 31'd6554;
  localparam logic signed [31:0] RST_REST_V      = 32'sd0;
  localparam logic signed [31:0] RST_THRESHOLD   = 32'sd65536;
  localparam logic signed [31:0] RST_RESET_V     = 32'sd0;
  localparam logic [15:0]        RST_REFR_TICKS  = 16'd2;
  localparam logic [30:0]        RST_MEMORY_GAIN = 31'd65536;
  localparam logic [HLEN_W-1:0]  RST_HIST_LEN    = 11'd1024;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAC,
    MUL_LEAK,
    MUL_DRIVE,
    MUL_MEM
  } flif_mul_e;

  typedef struct packed {
    logic      clear_wr;
    logic      load_coeff;
    logic      start;
    logic      mac_issue;
    logic      frac_load;
    flif_mul_e mul_op;
    logic      commit;
  } flif_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic active;
    logic issue_last;
    logic mac_busy;
    logic out_free;
  } flif_sts_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if ((&x[63:31]) || !(|x[63:31])) begin
      r = x[31:0];
    end else if (x[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### hdl/flif_ram.sv
// ----------------------------------------------------------------------------
// flif_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module flif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/flif_ctrl.sv
// ----------------------------------------------------------------------------
// flif_ctrl
// Sequencer of the neuron step: ring clear after reset, input transfers,
// memory sum, term multiplies and the final update.
// ----------------------------------------------------------------------------
module flif_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_mode_i,
  output logic               in_ready_o,
  input  flif_pkg::flif_sts_t sts_i,
  output flif_pkg::flif_cmd_t cmd_o
);
  import flif_pkg::*;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_MAC     = 4'd2;
  localparam logic [3:0] ST_DRAIN   = 4'd3;
  localparam logic [3:0] ST_FRAC    = 4'd4;
  localparam logic [3:0] ST_LEAK    = 4'd5;
  localparam logic [3:0] ST_DRIVE   = 4'd6;
  localparam logic [3:0] ST_MEMT    = 4'd7;
  localparam logic [3:0] ST_SETTLE  = 4'd8;
  localparam logic [3:0] ST_RESOLVE = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{default: '0, mul_op: MUL_NONE};
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.load_coeff = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.active ? ST_MAC : ST_RESOLVE;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.mac_busy) begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        cmd_o.frac_load = 1'b1;
        state_d         = ST_LEAK;
      end
      ST_LEAK: begin
        cmd_o.mul_op = MUL_LEAK;
        state_d      = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd_o.mul_op = MUL_DRIVE;
        state_d      = ST_MEMT;
      end
      ST_MEMT: begin
        cmd_o.mul_op = MUL_MEM;
        state_d      = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/flif_datapath.sv
// ----------------------------------------------------------------------------
// flif_datapath
// Configuration registers, neuron state, history and coefficient memories,
// shared multiplier with accumulators, and the result register.
// ----------------------------------------------------------------------------
module flif_datapath #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [flif_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [flif_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [flif_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [flif_pkg::OUT_DATA_W-1:0]     out_data_o,
  input  flif_pkg::flif_cmd_t                 cmd_i,
  output flif_pkg::flif_sts_t                 sts_o
);
  import flif_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = (LW > HLEN_W) ? LW : HLEN_W;

  // configuration
  logic [30:0]        leak_gain_q, input_gain_q, memory_gain_q;
  logic signed [31:0] rest_v_q, threshold_q, reset_v_q;
  logic [15:0]        refr_ticks_q;
  logic [HLEN_W-1:0]  hist_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_gain_q   <= RST_LEAK_GAIN;
      input_gain_q  <= RST_INPUT_GAIN;
      rest_v_q      <= RST_REST_V;
      threshold_q   <= RST_THRESHOLD;
      reset_v_q     <= RST_RESET_V;
      refr_ticks_q  <= RST_REFR_TICKS;
      memory_gain_q <= RST_MEMORY_GAIN;
      hist_len_q    <= RST_HIST_LEN;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LEAK_GAIN:   leak_gain_q   <= cfg_wdata_i[30:0];
        CFG_INPUT_GAIN:  input_gain_q  <= cfg_wdata_i[30:0];
        CFG_REST_V:      rest_v_q      <= cfg_wdata_i;
        CFG_THRESHOLD:   threshold_q   <= cfg_wdata_i;
        CFG_RESET_V:     reset_v_q     <= cfg_wdata_i;
        CFG_REFR_TICKS:  refr_ticks_q  <= cfg_wdata_i[15:0];
        CFG_MEMORY_GAIN: memory_gain_q <= cfg_wdata_i[30:0];
        CFG_HIST_LEN:    hist_len_q    <= cfg_wdata_i[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input payload
  logic [9:0]         in_coeff_index;
  logic signed [31:0] in_coeff_value, in_current;

  assign in_coeff_index = in_data_i[9:0];
  assign in_coeff_value = in_data_i[41:10];
  assign in_current     = in_data_i[73:42];

  // neuron state
  logic signed [31:0] membrane_q;
  logic [AW-1:0]      ring_head_q;
  logic [LW-1:0]      step_count_q;
  logic [REFR_W-1:0]  refr_q;

  // per-step working registers
  logic [LW-1:0]      len_q, count_q, limit_q, k_q;
  logic [AW-1:0]      head_q, idx_q, clr_q;
  logic signed [31:0] cur_q, frac_q;
  logic signed [32:0] diff_q;
  logic               active_q;
  logic               rd_v_q;
  flif_mul_e          prod_op_q;
  logic signed [65:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [TERM_W-1:0] term_q;

  // effective length, head and count
  logic [CW-1:0] hl_ext;
  logic [LW-1:0] len_c, head_ext, count_c, limit_c;
  logic [AW-1:0] head_c;

  always_comb begin
    hl_ext = CW'(hist_len_q);
    if (hl_ext == '0) begin
      len_c = LW'(1);
    end else if (hl_ext > CW'(HISTORY_DEPTH)) begin
      len_c = LW'(HISTORY_DEPTH);
    end else begin
      len_c = LW'(hl_ext);
    end
    head_ext = LW'(ring_head_q);
    head_c   = (head_ext >= len_c) ? '0 : ring_head_q;
    count_c  = (step_count_q > len_c) ? len_c : step_count_q;
    limit_c  = (count_c < len_c) ? count_c + LW'(1) : len_c;
  end

  // memories
  logic [31:0]   coeff_rdata, ring_rdata, ring_wdata;
  logic          coeff_we, ring_we;
  logic [AW-1:0] ring_waddr;

  assign coeff_we = cmd_i.load_coeff && (32'(in_coeff_index) < 32'(HISTORY_DEPTH));

  flif_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (coeff_we),
    .waddr_i (AW'(in_coeff_index)),
    .wdata_i (in_coeff_value),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (coeff_rdata)
  );

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = head_q;
    ring_wdata = membrane_q;
    if (cmd_i.clear_wr) begin
      ring_we    = 1'b1;
      ring_waddr = clr_q;
      ring_wdata = '0;
    end else if (cmd_i.commit && active_q) begin
      ring_we = 1'b1;
    end
  end

  flif_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (idx_q),
    .rdata_o (ring_rdata)
  );

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  flif_mul_e          mul_op;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = MUL_NONE;
    if (rd_v_q) begin
      mul_op = MUL_MAC;
      mul_a  = 33'($signed(coeff_rdata));
      mul_b  = 33'($signed(ring_rdata));
    end else begin
      mul_op = cmd_i.mul_op;
      case (cmd_i.mul_op)
        MUL_LEAK: begin
          mul_a = $signed({2'b00, leak_gain_q});
          mul_b = diff_q;
        end
        MUL_DRIVE: begin
          mul_a = $signed({2'b00, input_gain_q});
          mul_b = 33'(cur_q);
        end
        MUL_MEM: begin
          mul_a = $signed({2'b00, memory_gain_q});
          mul_b = 33'(frac_q);
        end
        default: ;
      endcase
    end
  end

  // accumulation
  logic signed [64:0]       mac_sum;
  logic signed [63:0]       acc_d;
  logic signed [49:0]       prod_sh;
  logic signed [33:0]       acc_sh;
  logic signed [31:0]       vnew_raw, vnew;
  logic                     fire;

  always_comb begin
    mac_sum = 65'(acc_q) + 65'($signed(prod_q[63:0]));
    if (mac_sum[64] != mac_sum[63]) begin
      acc_d = mac_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      acc_d = mac_sum[63:0];
    end
    prod_sh  = $signed(prod_q[65:16]);
    acc_sh   = $signed(acc_q[63:30]);
    vnew_raw = sat_s32(64'(term_q));
    fire     = active_q && (vnew_raw >= threshold_q);
    vnew     = (!active_q || fire) ? reset_v_q : vnew_raw;
  end

  // step sequencing
  logic [LW-1:0] k_inc, head_inc;

  assign k_inc    = k_q + LW'(1);
  assign head_inc = LW'(head_q) + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      rd_v_q       <= 1'b0;
      prod_op_q    <= MUL_NONE;
      active_q     <= 1'b0;
      membrane_q   <= RST_RESET_V;
      ring_head_q  <= '0;
      step_count_q <= '0;
      refr_q       <= '1;
      out_valid_o  <= 1'b0;
    end else begin
      rd_v_q    <= cmd_i.mac_issue;
      prod_op_q <= mul_op;
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.start) begin
        active_q <= sts_o.active;
      end
      if (cmd_i.commit) begin
        membrane_q   <= vnew;
        ring_head_q  <= (head_inc >= len_q) ? '0 : AW'(head_inc);
        step_count_q <= (count_q < len_q) ? count_q + LW'(1) : count_q;
        if (fire) begin
          refr_q <= REFR_W'(1);
        end else if (refr_q != '1) begin
          refr_q <= refr_q + REFR_W'(1);
        end
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  logic        out_spike_q;
  logic [31:0] out_voltage_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.start) begin
      len_q   <= len_c;
      head_q  <= head_c;
      count_q <= count_c;
      limit_q <= limit_c;
      k_q     <= '0;
      idx_q   <= head_c;
      cur_q   <= in_current;
      diff_q  <= 33'(rest_v_q) - 33'(membrane_q);
      acc_q   <= '0;
      term_q  <= TERM_W'(membrane_q);
    end else begin
      if (cmd_i.mac_issue) begin
        k_q   <= k_inc;
        idx_q <= (idx_q == '0) ? AW'(len_q - LW'(1)) : idx_q - AW'(1);
      end
      case (prod_op_q)
        MUL_MAC:   acc_q  <= acc_d;
        MUL_LEAK:  term_q <= term_q + TERM_W'(prod_sh);
        MUL_DRIVE: term_q <= term_q + TERM_W'(prod_sh);
        MUL_MEM:   term_q <= term_q - TERM_W'(prod_sh);
        default: ;
      endcase
    end
    if (cmd_i.frac_load) begin
      frac_q <= sat_s32(64'(acc_sh));
    end
    if (cmd_i.commit) begin
      out_spike_q   <= fire;
      out_voltage_q <= vnew;
    end
  end

  assign out_data_o = {7'b0, out_voltage_q, out_spike_q};

  assign sts_o.clear_last = (clr_q == AW'(HISTORY_DEPTH - 1));
  assign sts_o.active     = (refr_q > {1'b0, refr_ticks_q});
  assign sts_o.issue_last = (k_inc == limit_q);
  assign sts_o.mac_busy   = rd_v_q || (prod_op_q != MUL_NONE);
  assign sts_o.out_free   = !out_valid_o || out_ready_i;

endmodule

### hdl/fractional_lif_neuron_step_unit.sv
// ----------------------------------------------------------------------------
// fractional_lif_neuron_step_unit
// Fractional leaky integrate-and-fire neuron, one time step per step transfer.
// ----------------------------------------------------------------------------
// After reset the history ring is cleared, one entry per cycle, with
// s_axis_tready low; configuration writes are taken throughout. A
// coefficient load transfer (tuser high) gives no result. A time step
// outside refractory forms N coefficient-voltage products, where
// N = min(steps so far + 1, history length): the memory sum runs one
// multiply-accumulate per cycle through one registered read of each
// memory, then three term multiplies share the same multiplier. A step
// inside refractory skips the memory sum and the term multiplies. One
// result register sits on the output side, so a new transfer is accepted
// while a result waits. Coefficients must be loaded before the steps that
// read them.
// ----------------------------------------------------------------------------
module fractional_lif_neuron_step_unit #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [flif_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [flif_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coeff_index, coeff_value, input_current, zero fill
  input  logic [flif_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [flif_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // spike, voltage, zero fill
  output logic [flif_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import flif_pkg::*;

  flif_cmd_t cmd;
  flif_sts_t sts;

  flif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flif_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
